>>> sv/elliptical_vignette_fade_defines.svh
// assertion helpers for the vignette fade block
`ifndef ELLIPTICAL_VIGNETTE_FADE_DEFINES_SVH
`define ELLIPTICAL_VIGNETTE_FADE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define EVF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define EVF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/evf_pkg.sv
package evf_pkg;

    localparam int unsigned ONE_Q16 = 65536;

    // derived constants shared by the constant unit and the pixel pipe
    typedef struct packed {
        logic [24:0] inv_w;
        logic [24:0] inv_h;
        logic [12:0] band;
        logic [32:0] recip;
    } t_consts;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_LOAD,
        CS_RUN
    } t_cst_state;

    typedef enum logic [1:0] {
        JOB_INVW,
        JOB_INVH,
        JOB_BAND,
        JOB_RECIP
    } t_job;

    // square root working set, two result bits per pipe stage
    typedef struct packed {
        logic [39:0] v;
        logic [22:0] rem;
        logic [19:0] root;
    } t_sq;

    function automatic t_sq sq_step(input t_sq a);
        t_sq         o;
        logic [22:0] rem2;
        logic [22:0] trial;
        rem2  = {a.rem[20:0], a.v[39:38]};
        trial = {1'b0, a.root, 2'b01};
        o.v   = {a.v[37:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {a.root[18:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {a.root[18:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> sv/evf_consts.sv
module evf_consts (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [12:0]      i_w,
    input  logic [12:0]      i_h,
    output evf_pkg::t_consts o_consts,
    output logic             o_busy
);

    evf_pkg::t_cst_state r_state, n_state;
    evf_pkg::t_job       r_job;
    logic [5:0]          r_cnt;
    logic [32:0]         r_quo;
    logic [20:0]         r_rem;
    logic [20:0]         r_div;
    evf_pkg::t_consts    r_consts;

    logic        last_step;
    logic [21:0] rem2;
    logic [32:0] ld_dvd;
    logic [20:0] ld_div;
    logic [12:0] mn;

    assign mn   = (i_w < i_h) ? i_w : i_h;
    assign rem2 = {r_rem, r_quo[32]};

    // operands of each job
    always_comb begin
        case (r_job)
            evf_pkg::JOB_INVW: begin
                ld_dvd = 33'd1677721600;
                ld_div = 21'(i_w) * 21'd94;
            end
            evf_pkg::JOB_INVH: begin
                ld_dvd = 33'd1677721600;
                ld_div = 21'(i_h) * 21'd94;
            end
            evf_pkg::JOB_BAND: begin
                ld_dvd = {4'd0, mn, 16'd0};
                ld_div = 21'(i_w) * 21'd10;
            end
            evf_pkg::JOB_RECIP: begin
                ld_dvd = {1'b1, 32'd0};
                ld_div = {8'd0, r_consts.band};
            end
            default: begin
                ld_dvd = '0;
                ld_div = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            evf_pkg::CS_IDLE: if (i_start) n_state = evf_pkg::CS_LOAD;
            evf_pkg::CS_LOAD: n_state = evf_pkg::CS_RUN;
            evf_pkg::CS_RUN: begin
                if (last_step) begin
                    n_state = (r_job == evf_pkg::JOB_RECIP) ? evf_pkg::CS_IDLE
                                                            : evf_pkg::CS_LOAD;
                end
            end
            default: n_state = evf_pkg::CS_IDLE;
        endcase
        if (i_start) n_state = evf_pkg::CS_LOAD;
    end

    // outputs
    always_comb begin
        o_busy    = (r_state != evf_pkg::CS_IDLE);
        last_step = (r_state == evf_pkg::CS_RUN) && (r_cnt == 6'd32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evf_pkg::CS_LOAD;
            r_job   <= evf_pkg::JOB_INVW;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_job <= evf_pkg::JOB_INVW;
            end else if (last_step && r_job != evf_pkg::JOB_RECIP) begin
                r_job <= evf_pkg::t_job'(r_job + 2'd1);
            end
            if (r_state == evf_pkg::CS_RUN) r_cnt <= r_cnt + 6'd1;
            else                            r_cnt <= '0;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        logic [32:0] q;
        q = {r_quo[31:0], 1'b0};
        if (r_state == evf_pkg::CS_LOAD) begin
            r_quo <= ld_dvd;
            r_rem <= '0;
            r_div <= ld_div;
        end else if (r_state == evf_pkg::CS_RUN) begin
            if (rem2 >= {1'b0, r_div}) begin
                r_rem <= 21'(rem2 - {1'b0, r_div});
                q[0]  = 1'b1;
            end else begin
                r_rem <= rem2[20:0];
            end
            r_quo <= q;
            if (last_step) begin
                case (r_job)
                    evf_pkg::JOB_INVW:  r_consts.inv_w <= q[24:0];
                    evf_pkg::JOB_INVH:  r_consts.inv_h <= q[24:0];
                    evf_pkg::JOB_BAND:  r_consts.band  <= q[12:0];
                    evf_pkg::JOB_RECIP: r_consts.recip <= q;
                    default:            r_consts.recip <= q;
                endcase
            end
        end
    end

    assign o_consts = r_consts;

endmodule

>>> sv/elliptical_vignette_fade.sv
// the pipe has 21 register stages, the square root takes ten of them (two bits each)
// throughput: one pixel per cycle sustained while i_ready stays high and no recompute runs
// reset: dimensions return to 512 and the constant unit recomputes radii reciprocals,
// band and band reciprocal, with i_valid not taken (o_ready low) until it is done
// every configuration write restarts that same recompute
`include "elliptical_vignette_fade_defines.svh"

module elliptical_vignette_fade #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    input  logic [23:0] i_pixel_rgb,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_gray_out
);

    localparam int NST = 21;

    // configuration registers
    logic [12:0] r_width, r_height;
    logic [12:0] w_c, h_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd512;
            r_height <= 13'd512;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 2'd0) r_width  <= i_cfg_data;
            if (i_cfg_idx == 2'd1) r_height <= i_cfg_data;
        end
    end

    // zero acts as one, oversized saturates
    function automatic logic [12:0] clamp_dim(input logic [12:0] d);
        if (d == 13'd0)                   return 13'd1;
        if ({19'd0, d} > 32'(MAX_DIM))    return 13'(MAX_DIM);
        return d;
    endfunction

    assign w_c = clamp_dim(r_width);
    assign h_c = clamp_dim(r_height);

    evf_pkg::t_consts cst;
    logic             cst_busy;

    evf_consts u_consts (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_w      (w_c),
        .i_h      (h_c),
        .o_consts (cst),
        .o_busy   (cst_busy)
    );

    // stage enables: a stage moves when empty or when the one after it moves
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) en[k] = !r_vld[k] || en[k+1];
    end

    assign o_ready = en[0] && !cst_busy;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid && !cst_busy;
            for (int k = 1; k < NST; k++) if (en[k]) r_vld[k] <= r_vld[k-1];
        end
    end

    // gray level rides along the pipe
    logic [7:0] r_gray [0:NST-2];
    logic [12:0] gray_sum;
    assign gray_sum = 13'(11 * {5'd0, i_pixel_rgb[23:16]}) + {1'b0, i_pixel_rgb[15:8], 4'd0}
                    + 13'(5 * {5'd0, i_pixel_rgb[7:0]});

    always_ff @(posedge i_clk) begin
        if (en[0]) r_gray[0] <= gray_sum[12:5];
        for (int k = 1; k < NST - 1; k++) if (en[k]) r_gray[k] <= r_gray[k-1];
    end

    // stage 0: distance from centre in half-pixels
    logic [12:0] r_dx, r_dy;
    logic [12:0] px2, py2;
    assign px2 = {i_column, 1'b0};
    assign py2 = {i_row, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= (px2 > w_c) ? px2 - w_c : w_c - px2;
            r_dy <= (py2 > h_c) ? py2 - h_c : h_c - py2;
        end
    end

    // stage 1: scale by the radius reciprocal, Q2.16 with saturation
    logic [37:0] mx, my;
    logic [17:0] r_nx, r_ny;
    assign mx = 38'(r_dx) * 38'(cst.inv_w);
    assign my = 38'(r_dy) * 38'(cst.inv_h);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_nx <= (|mx[37:26]) ? 18'h3FFFF : mx[25:8];
            r_ny <= (|my[37:26]) ? 18'h3FFFF : my[25:8];
        end
    end

    // stages 2 and 3: squares, then their sum
    logic [35:0] r_sqx, r_sqy;
    logic [36:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_sqx <= 36'(r_nx) * 36'(r_nx);
            r_sqy <= 36'(r_ny) * 36'(r_ny);
        end
        if (en[3]) r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    // stages 4 to 13: digit-by-digit square root, two steps per stage
    evf_pkg::t_sq r_sq [4:13];
    evf_pkg::t_sq sq_init;
    assign sq_init = '{v: {3'd0, r_sum}, rem: '0, root: '0};

    always_ff @(posedge i_clk) begin
        if (en[4]) r_sq[4] <= evf_pkg::sq_step(evf_pkg::sq_step(sq_init));
        for (int k = 5; k <= 13; k++) begin
            if (en[k]) r_sq[k] <= evf_pkg::sq_step(evf_pkg::sq_step(r_sq[k-1]));
        end
    end

    // stage 14: region decisions and offset into the band
    logic [18:0] d_q16;
    logic [16:0] inner;
    logic [18:0] doff;
    logic        r_gt14, r_inb14;
    logic [12:0] r_x14;
    assign d_q16 = r_sq[13].root[18:0];
    assign inner = 17'(evf_pkg::ONE_Q16) - {4'd0, cst.band};
    assign doff  = d_q16 - {2'd0, inner};

    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r_gt14  <= d_q16 > 19'(evf_pkg::ONE_Q16);
            r_inb14 <= (cst.band != 13'd0) && (d_q16 > {2'd0, inner});
            r_x14   <= doff[12:0];
        end
    end

    // stages 15 to 17: t = x * 2^16 / band by reciprocal and one correction
    logic [45:0] r_prod15;
    logic [12:0] r_x15, r_x16;
    logic        r_gt15, r_inb15, r_gt16, r_inb16, r_gt17, r_inb17;
    logic [16:0] r_qe16;
    logic [29:0] r_qb16;
    logic [16:0] qe;
    logic [28:0] rem_t;
    logic [16:0] t_corr;
    logic [16:0] r_t17;
    assign qe     = r_prod15[32:16];
    assign rem_t  = {r_x16, 16'd0} - r_qb16[28:0];
    assign t_corr = (rem_t >= {16'd0, cst.band}) ? r_qe16 + 17'd1 : r_qe16;

    always_ff @(posedge i_clk) begin
        if (en[15]) begin
            r_prod15 <= 46'(r_x14) * 46'(cst.recip);
            r_x15    <= r_x14;
            r_gt15   <= r_gt14;
            r_inb15  <= r_inb14;
        end
        if (en[16]) begin
            r_qe16  <= qe;
            r_qb16  <= 30'(qe) * 30'(cst.band);
            r_x16   <= r_x15;
            r_gt16  <= r_gt15;
            r_inb16 <= r_inb15;
        end
        if (en[17]) begin
            r_t17   <= (t_corr > 17'(evf_pkg::ONE_Q16)) ? 17'(evf_pkg::ONE_Q16) : t_corr;
            r_gt17  <= r_gt16;
            r_inb17 <= r_inb16;
        end
    end

    // stages 18 and 19: smoothstep, then alpha select
    logic [16:0] r_s18, r_t18, r_alpha19;
    logic        r_gt18, r_inb18, r_gt19;
    logic [33:0] tt;
    logic [17:0] lin;
    logic [34:0] kk;
    logic [16:0] kc;
    assign tt  = 34'(r_t17) * 34'(r_t17);
    assign lin = 18'd196608 - {r_t18, 1'b0};
    assign kk  = 35'(r_s18) * 35'(lin);
    assign kc  = (|kk[34:32]) || (kk[31:16] != 16'd0 && kk[32]) ? 17'(evf_pkg::ONE_Q16)
               : ((kk[32:16] > 17'(evf_pkg::ONE_Q16)) ? 17'(evf_pkg::ONE_Q16) : kk[32:16]);

    always_ff @(posedge i_clk) begin
        if (en[18]) begin
            r_s18   <= tt[32:16];
            r_t18   <= r_t17;
            r_gt18  <= r_gt17;
            r_inb18 <= r_inb17;
        end
        if (en[19]) begin
            if (r_gt18)       r_alpha19 <= '0;
            else if (r_inb18) r_alpha19 <= 17'(evf_pkg::ONE_Q16) - kc;
            else              r_alpha19 <= 17'(evf_pkg::ONE_Q16);
            r_gt19 <= r_gt18;
        end
    end

    // stage 20: blend toward white, output register
    logic [16:0] beta;
    logic [24:0] blend;
    logic [7:0]  r_out;
    assign beta  = 17'(evf_pkg::ONE_Q16) - r_alpha19;
    assign blend = 25'(r_gray[19]) * 25'(r_alpha19) + ({8'd0, beta} << 8) - {8'd0, beta};

    always_ff @(posedge i_clk) begin
        if (en[20]) r_out <= (|blend[24:24]) ? 8'd255 : blend[23:16];
    end

    assign o_gray_out = r_out;

    // a register write must hold off input while constants are rebuilt
    `EVF_ASSERT_NXT(a_cfg_blocks_input, i_cfg_we, !o_ready, "input taken during recompute")
    // corrected quotient never leaves the unit interval
    `EVF_ASSERT_IMP(a_t_range, r_vld[17] && r_inb17 && !r_gt17,
                    r_t17 <= 17'(evf_pkg::ONE_Q16), "band position out of range")
    // outside the ellipse the pixel comes out white
    `EVF_ASSERT_NXT(a_outside_white, r_vld[19] && r_gt19 && en[20],
                    o_gray_out == 8'd255, "outside pixel not white")

endmodule
